// ===== hw/rtl/fknc_pkg.sv =====
// Package for the keyword name checker: status codes, reserved word table,
// character class helpers and the one-pass classify function.
// No dependencies.
package fknc_pkg;

   localparam int unsigned MAX_NAME_CHARS = 8;
   localparam int unsigned NAME_BITS      = 8 * MAX_NAME_CHARS;
   localparam int unsigned NUM_RESERVED   = 10;
   localparam int unsigned NAXIS_CHARS    = 5;

   typedef logic [NAME_BITS-1:0] name_type;
   typedef logic [3:0]           len_type;
   typedef logic [1:0]           status_type;

   localparam status_type STATUS_VALID    = 2'd0;
   localparam status_type STATUS_INVALID  = 2'd1;
   localparam status_type STATUS_RESERVED = 2'd2;

   // Scan phase of the text after the NAXIS prefix
   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGIT,
      PH_BAD
   } phase_type;

   // Reserved words, lower case, first char in the low byte, zero padded
   localparam logic [NAME_BITS-1:0] RSV_WORD [NUM_RESERVED] = '{
      64'h0000656C706D6973,   // simple
      64'h0000646E65747865,   // extend
      64'h0000006F72657A62,   // bzero
      64'h0000656C61637362,   // bscale
      64'h0000006B6E616C62,   // blank
      64'h0000786970746962,   // bitpix
      64'h000000736978616E,   // naxis
      64'h00746E656D6D6F63,   // comment
      64'h0079726F74736968,   // history
      64'h0000000000646E65    // end
   };

   localparam len_type RSV_LEN [NUM_RESERVED] = '{
      4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd7, 4'd7, 4'd3
   };

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_SPACE = 8'h20;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic char_ok(input logic [7:0] c);
      return c == CH_MINUS || c == CH_UNDER || (c >= 8'h41 && c <= 8'h5A) || is_digit(c);
   endfunction

   // Tail after "naxis": spaces, optional '+', digits, nonzero value.
   // At most three chars, so the value never exceeds 999.
   function automatic logic naxis_tail_ok(input logic [23:0] tail, input len_type len);
      phase_type  ph;
      logic       nonzero;
      logic [7:0] c;
      ph      = PH_SPACE;
      nonzero = 1'b0;
      for (int p = 0; p < 3; p++) begin
         c = tail[8*p +: 8];
         if (4'(NAXIS_CHARS + p) < len) begin
            unique case (ph)
               PH_SPACE: begin
                  if (is_space(c))      ph = PH_SPACE;
                  else if (c == CH_PLUS) ph = PH_SIGN;
                  else if (is_digit(c)) ph = PH_DIGIT;
                  else                  ph = PH_BAD;
               end
               PH_SIGN, PH_DIGIT: begin
                  ph = is_digit(c) ? PH_DIGIT : PH_BAD;
               end
               default: ph = PH_BAD;
            endcase
            if (is_digit(c) && c != 8'h30) nonzero = 1'b1;
         end
      end
      return ph == PH_DIGIT && nonzero;
   endfunction

   function automatic status_type classify(input name_type bytes, input len_type len);
      name_type   low;
      name_type   mask;
      logic       rsv;
      logic       bad;
      low  = '0;
      mask = '0;
      rsv  = 1'b0;
      bad  = 1'b0;
      for (int i = 0; i < MAX_NAME_CHARS; i++) begin
         if (4'(i) < len) begin
            low[8*i +: 8]  = to_lower(bytes[8*i +: 8]);
            mask[8*i +: 8] = 8'hFF;
            if (!char_ok(bytes[8*i +: 8])) bad = 1'b1;
         end
      end
      for (int k = 0; k < NUM_RESERVED; k++) begin
         if (RSV_LEN[k] == len && (low & mask) == RSV_WORD[k]) rsv = 1'b1;
      end
      if (len > 4'(NAXIS_CHARS) &&
          low[8*NAXIS_CHARS-1:0] == RSV_WORD[6][8*NAXIS_CHARS-1:0] &&
          naxis_tail_ok(bytes[8*NAXIS_CHARS +: 24], len)) begin
         rsv = 1'b1;
      end
      if (len > 4'(MAX_NAME_CHARS)) return STATUS_INVALID;
      if (rsv)                      return STATUS_RESERVED;
      if (bad)                      return STATUS_INVALID;
      return STATUS_VALID;
   endfunction

endpackage

// ===== hw/rtl/fits_keyword_name_check_core.sv =====
// Keyword name checker top level: input register, one-pass classify,
// result register. Depends on fknc_pkg.
//
// Throughput: one name per cycle; busy stays low, the two register stages
//   overlap so a new name is taken every cycle.
// Reset (synchronous, active high) clears both valid flags; payload
//   registers are not reset. The receiver cannot stall the result.
module fits_keyword_name_check_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fknc_pkg::name_type   req_name_bytes,
   input  fknc_pkg::len_type    req_name_length,
   output logic                 rsp_valid,
   output fknc_pkg::status_type rsp_status
);
   import fknc_pkg::*;

   // Stage 1: captured request
   logic       req_valid_ff;
   logic       req_valid_in;
   name_type   req_bytes_ff;
   len_type    req_len_ff;

   // Stage 2: result
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   status_type rsp_status_in;

   // No internal backpressure: every stage advances each cycle.
   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) begin
         req_bytes_ff <= req_name_bytes;
         req_len_ff   <= req_name_length;
      end
   end

   // Reserved-word match, NAXIS-number tail scan and per-char class check
   // all run in parallel; the reserved test wins over the char check,
   // and an over-long name is invalid outright.
   assign rsp_status_in = classify(req_bytes_ff, req_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Each result is shown for one cycle only
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
